### src/elt_pkg.sv
package elt_pkg;

   // Width of the running byte position counter.
   localparam int POS_BITS = 16;

   // Token queue between the scanner and the result port.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // Token kinds.
   localparam logic [4:0] K_SET     = 5'd0;
   localparam logic [4:0] K_RETURN  = 5'd1;
   localparam logic [4:0] K_LBRACE  = 5'd2;
   localparam logic [4:0] K_RBRACE  = 5'd3;
   localparam logic [4:0] K_LPAREN  = 5'd4;
   localparam logic [4:0] K_RPAREN  = 5'd5;
   localparam logic [4:0] K_COLON   = 5'd6;
   localparam logic [4:0] K_SEMI    = 5'd7;
   localparam logic [4:0] K_ASSIGN  = 5'd8;
   localparam logic [4:0] K_AND     = 5'd9;
   localparam logic [4:0] K_OR      = 5'd10;
   localparam logic [4:0] K_NOT     = 5'd11;
   localparam logic [4:0] K_XOR     = 5'd12;
   localparam logic [4:0] K_LSHIFT  = 5'd13;
   localparam logic [4:0] K_RSHIFT  = 5'd14;
   localparam logic [4:0] K_PLUS    = 5'd15;
   localparam logic [4:0] K_MINUS   = 5'd16;
   localparam logic [4:0] K_STAR    = 5'd17;
   localparam logic [4:0] K_DIV     = 5'd18;
   localparam logic [4:0] K_ID      = 5'd19;
   localparam logic [4:0] K_DEC     = 5'd20;
   localparam logic [4:0] K_HEX     = 5'd21;
   localparam logic [4:0] K_UNKNOWN = 5'd22;
   localparam logic [4:0] K_END     = 5'd23;

   // One result beat.
   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } token_type;

   // Tokens the scanner hands to the queue for one accepted beat.
   typedef struct packed {
      logic      valid0;
      logic      valid1;
      token_type tok0;
      token_type tok1;
   } push_type;

endpackage

### src/elt_scan.sv
module elt_scan (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        source_byte,
   input  logic              end_of_source,
   output elt_pkg::push_type push
);

   // Scan modes.
   localparam logic [3:0] MODE_IDLE    = 4'd0;
   localparam logic [3:0] MODE_IDENT   = 4'd1;
   localparam logic [3:0] MODE_DEC     = 4'd2;
   localparam logic [3:0] MODE_ZERO    = 4'd3;
   localparam logic [3:0] MODE_HEX     = 4'd4;
   localparam logic [3:0] MODE_SLASH   = 4'd5;
   localparam logic [3:0] MODE_GT      = 4'd6;
   localparam logic [3:0] MODE_LT      = 4'd7;
   localparam logic [3:0] MODE_COMMENT = 4'd8;

   // Keyword candidates.
   localparam logic [1:0] KC_NONE   = 2'd0;
   localparam logic [1:0] KC_SET    = 2'd1;
   localparam logic [1:0] KC_RETURN = 2'd2;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   function automatic logic is_xdigit(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      unique case (c)
         "{":     k = elt_pkg::K_LBRACE;
         "}":     k = elt_pkg::K_RBRACE;
         "(":     k = elt_pkg::K_LPAREN;
         ")":     k = elt_pkg::K_RPAREN;
         ":":     k = elt_pkg::K_COLON;
         ";":     k = elt_pkg::K_SEMI;
         "=":     k = elt_pkg::K_ASSIGN;
         "&":     k = elt_pkg::K_AND;
         "|":     k = elt_pkg::K_OR;
         "~":     k = elt_pkg::K_NOT;
         "^":     k = elt_pkg::K_XOR;
         "+":     k = elt_pkg::K_PLUS;
         "-":     k = elt_pkg::K_MINUS;
         "*":     k = elt_pkg::K_STAR;
         default: k = elt_pkg::K_UNKNOWN;
      endcase
      return k;
   endfunction

   // Character of a keyword at a given place; zero past its end.
   function automatic logic [7:0] kw_char(input logic [1:0] cand, input logic [2:0] idx);
      logic [7:0] ch;
      ch = 8'h00;
      if (cand == KC_SET) begin
         unique case (idx)
            3'd0:    ch = "s";
            3'd1:    ch = "e";
            3'd2:    ch = "t";
            default: ch = 8'h00;
         endcase
      end else if (cand == KC_RETURN) begin
         unique case (idx)
            3'd0:    ch = "r";
            3'd1:    ch = "e";
            3'd2:    ch = "t";
            3'd3:    ch = "u";
            3'd4:    ch = "r";
            3'd5:    ch = "n";
            default: ch = 8'h00;
         endcase
      end
      return ch;
   endfunction

   function automatic logic [2:0] kw_len(input logic [1:0] cand);
      return (cand == KC_SET) ? 3'd3 : 3'd6;
   endfunction

   logic [3:0]                   mode_ff, mode_in;
   logic [elt_pkg::POS_BITS-1:0] pos_ff, pos_in;
   logic [elt_pkg::POS_BITS-1:0] start_ff, start_in;
   logic [15:0]                  len_ff, len_in;
   logic [2:0]                   kprog_ff, kprog_in;
   logic [1:0]                   kcand_ff, kcand_in;

   logic                         pend_has;
   logic [4:0]                   pend_kind;
   logic                         close_v, sec_v, do_close, do_start;
   elt_pkg::token_type           close_tok, sec_tok;
   logic [15:0]                  len_grown;

   // Kind of the open token if it were closed now.
   always_comb begin
      pend_has  = 1'b1;
      pend_kind = elt_pkg::K_UNKNOWN;
      unique case (mode_ff)
         MODE_IDENT: begin
            pend_kind = elt_pkg::K_ID;
            if (kcand_ff == KC_SET && kprog_ff == 3'd3) begin
               pend_kind = elt_pkg::K_SET;
            end
            if (kcand_ff == KC_RETURN && kprog_ff == 3'd6) begin
               pend_kind = elt_pkg::K_RETURN;
            end
         end
         MODE_DEC, MODE_ZERO: pend_kind = elt_pkg::K_DEC;
         MODE_HEX:            pend_kind = elt_pkg::K_HEX;
         MODE_SLASH:          pend_kind = elt_pkg::K_DIV;
         MODE_GT, MODE_LT:    pend_kind = elt_pkg::K_UNKNOWN;
         default:             pend_has  = 1'b0;
      endcase
   end

   assign len_grown = (len_ff != 16'hFFFF) ? len_ff + 16'd1 : len_ff;

   // Next scan state and the tokens this byte closes.
   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      kprog_in  = kprog_ff;
      kcand_in  = kcand_ff;
      close_v   = 1'b0;
      sec_v     = 1'b0;
      do_close  = 1'b0;
      do_start  = 1'b0;
      sec_tok   = '0;

      close_tok.kind   = pend_kind;
      close_tok.start  = 16'(start_ff);
      close_tok.length = len_ff;
      close_tok.last   = 1'b0;

      if (end_of_source || source_byte == 8'h00) begin
         // End of source: flush, emit the end token and return to reset state.
         close_v        = pend_has;
         sec_v          = 1'b1;
         sec_tok.kind   = elt_pkg::K_END;
         sec_tok.start  = 16'(pos_ff);
         sec_tok.length = 16'd0;
         mode_in        = MODE_IDLE;
         pos_in         = '0;
         start_in       = '0;
         len_in         = '0;
         kprog_in       = '0;
         kcand_in       = KC_NONE;
      end else begin
         pos_in = pos_ff + 1'b1;
         unique case (mode_ff)
            MODE_COMMENT: begin
               if (source_byte == 8'h0A || source_byte == 8'h0D) begin
                  mode_in = MODE_IDLE;
               end
            end
            MODE_IDENT: begin
               if (is_word(source_byte)) begin
                  len_in = len_grown;
                  if (kcand_ff != KC_NONE) begin
                     if (kprog_ff < kw_len(kcand_ff) &&
                         kw_char(kcand_ff, kprog_ff) == source_byte) begin
                        kprog_in = kprog_ff + 3'd1;
                     end else begin
                        kcand_in = KC_NONE;
                     end
                  end
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            MODE_DEC: begin
               if (is_digit(source_byte)) begin
                  len_in = len_grown;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            MODE_ZERO: begin
               if (source_byte == "x" || source_byte == "X") begin
                  mode_in = MODE_HEX;
                  len_in  = len_grown;
               end else if (is_digit(source_byte)) begin
                  mode_in = MODE_DEC;
                  len_in  = len_grown;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            MODE_HEX: begin
               if (is_xdigit(source_byte)) begin
                  len_in = len_grown;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (source_byte == "/") begin
                  mode_in = MODE_COMMENT;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            MODE_GT, MODE_LT: begin
               if ((mode_ff == MODE_GT && source_byte == ">") ||
                   (mode_ff == MODE_LT && source_byte == "<")) begin
                  sec_v          = 1'b1;
                  sec_tok.kind   = (mode_ff == MODE_GT) ? elt_pkg::K_RSHIFT
                                                        : elt_pkg::K_LSHIFT;
                  sec_tok.start  = 16'(start_ff);
                  sec_tok.length = 16'd2;
                  mode_in        = MODE_IDLE;
               end else begin
                  do_close = 1'b1;
                  do_start = 1'b1;
               end
            end
            default: begin
               do_start = 1'b1;
            end
         endcase

         // Close the open token.
         if (do_close) begin
            close_v  = pend_has;
            mode_in  = MODE_IDLE;
            kcand_in = KC_NONE;
            kprog_in = '0;
         end

         // Classify this byte at a token boundary.
         if (do_start) begin
            mode_in = MODE_IDLE;
            if (is_space(source_byte)) begin
               mode_in = MODE_IDLE;
            end else if (is_alpha(source_byte) || source_byte == "_") begin
               mode_in  = MODE_IDENT;
               start_in = pos_ff;
               len_in   = 16'd1;
               if (source_byte == "s") begin
                  kcand_in = KC_SET;
                  kprog_in = 3'd1;
               end else if (source_byte == "r") begin
                  kcand_in = KC_RETURN;
                  kprog_in = 3'd1;
               end else begin
                  kcand_in = KC_NONE;
                  kprog_in = 3'd0;
               end
            end else if (source_byte == "0") begin
               mode_in  = MODE_ZERO;
               start_in = pos_ff;
               len_in   = 16'd1;
            end else if (is_digit(source_byte)) begin
               mode_in  = MODE_DEC;
               start_in = pos_ff;
               len_in   = 16'd1;
            end else if (source_byte == "/") begin
               mode_in  = MODE_SLASH;
               start_in = pos_ff;
               len_in   = 16'd1;
            end else if (source_byte == ">") begin
               mode_in  = MODE_GT;
               start_in = pos_ff;
               len_in   = 16'd1;
            end else if (source_byte == "<") begin
               mode_in  = MODE_LT;
               start_in = pos_ff;
               len_in   = 16'd1;
            end else begin
               sec_v          = 1'b1;
               sec_tok.kind   = punct_kind(source_byte);
               sec_tok.start  = 16'(pos_ff);
               sec_tok.length = 16'd1;
            end
         end
      end
   end

   // Pack the closed tokens in order; the final one carries the last flag.
   always_comb begin
      push.valid0   = close_v | sec_v;
      push.valid1   = close_v & sec_v;
      push.tok0     = close_v ? close_tok : sec_tok;
      push.tok0.last = ~(close_v & sec_v);
      push.tok1      = sec_tok;
      push.tok1.last = 1'b1;
   end

   // Scan state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         kprog_ff <= '0;
         kcand_ff <= KC_NONE;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         kprog_ff <= kprog_in;
         kcand_ff <= kcand_in;
      end
   end

endmodule

### src/elt_queue.sv
module elt_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  elt_pkg::push_type                    push,
   input  logic                                 push_en,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output elt_pkg::token_type                   rsp_token,
   output logic [elt_pkg::QUEUE_CNT_BITS-1:0]   level
);

   elt_pkg::token_type                  mem_ff [elt_pkg::QUEUE_DEPTH];
   logic [elt_pkg::QUEUE_IDX_BITS-1:0]  head_ff, head_in;
   logic [elt_pkg::QUEUE_CNT_BITS-1:0]  count_ff, count_in;
   logic [elt_pkg::QUEUE_IDX_BITS-1:0]  tail, tail_next;
   logic                                pop, wr0, wr1;

   assign tail      = head_ff + count_ff[elt_pkg::QUEUE_IDX_BITS-1:0];
   assign tail_next = tail + 1'b1;
   assign wr0       = push_en & push.valid0;
   assign wr1       = push_en & push.valid1;

   // The head entry drives the result port; it holds while the receiver stalls.
   assign rsp_valid = count_ff != '0;
   assign rsp_token = mem_ff[head_ff];
   assign pop       = rsp_valid & ~rsp_stall;
   assign level     = count_ff;

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      count_in = count_ff + elt_pkg::QUEUE_CNT_BITS'(wr0) + elt_pkg::QUEUE_CNT_BITS'(wr1)
                 - elt_pkg::QUEUE_CNT_BITS'(pop);
   end

   // Token storage, written at the tail.
   always_ff @(posedge clock) begin
      if (wr0) begin
         mem_ff[tail] <= push.tok0;
      end
      if (wr1) begin
         mem_ff[tail_next] <= push.tok1;
      end
   end

   // Pointers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

endmodule

### src/expression_language_tokenizer.sv
// Streaming tokenizer for a small expression language.
// Request channel: one source byte per beat (req_source_byte), or an end
// marker (req_end_of_source, or a zero byte) that flushes the open token,
// emits an end token and returns the scanner to its reset state.
// Response channel: one token per beat with kind, start offset, length and
// rsp_last_of_item, which marks the final token caused by a request beat.
// A request beat causes zero, one or two tokens.
// Tokens of an accepted beat are registered into the token queue and are
// offered on the response port from the next cycle on, behind older tokens.
// Throughput: one request beat per cycle, limited by the response port,
// which moves one token per cycle out of a four-entry token queue;
// req_stall is raised while fewer than two queue entries are free.
// While the receiver stalls, the offered token holds and the scanner keeps
// taking bytes until fewer than two queue entries are free.
// Reset is synchronous: the scanner returns to idle at position zero and
// the token queue empties.
module expression_language_tokenizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_source_byte,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [15:0] rsp_token_start,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_item
);

   elt_pkg::push_type                   push;
   elt_pkg::token_type                  head_tok;
   logic [elt_pkg::QUEUE_CNT_BITS-1:0]  level;
   logic                                accept;

   // Take a byte only when the queue can absorb the two tokens it may cause.
   assign req_stall = level > elt_pkg::QUEUE_CNT_BITS'(elt_pkg::QUEUE_DEPTH - 2);
   assign accept    = req_valid & ~req_stall;

   elt_scan u_scan (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .source_byte   (req_source_byte),
      .end_of_source (req_end_of_source),
      .push          (push)
   );

   elt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_en   (accept),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_token (head_tok),
      .level     (level)
   );

   assign rsp_token_kind   = head_tok.kind;
   assign rsp_token_start  = head_tok.start;
   assign rsp_token_length = head_tok.length;
   assign rsp_last_of_item = head_tok.last;

`ifndef SYNTHESIS
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= elt_pkg::QUEUE_CNT_BITS'(elt_pkg::QUEUE_DEPTH))
      else $error("token queue overfilled");

   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_token_kind == elt_pkg::K_END) |->
      (rsp_last_of_item && rsp_token_length == 16'd0))
      else $error("end token not last or has nonzero length");

   a_accept_room: assert property (@(posedge clock) disable iff (reset)
      accept |=> level <= elt_pkg::QUEUE_CNT_BITS'(elt_pkg::QUEUE_DEPTH))
      else $error("byte accepted without queue room");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

### tb/sv/testbench.sv
module testbench;

   // Scanner states of the predictor.
   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_WORD, SCAN_DECIMAL, SCAN_ZERO, SCAN_HEX,
      SCAN_SLASH, SCAN_GREATER, SCAN_LESS, SCAN_COMMENT
   } scan_mode_type;

   // Keyword that an open identifier may still turn out to be.
   typedef enum logic [1:0] {WORD_NONE, WORD_SET, WORD_RETURN} keyword_type;

   localparam logic [7:0] LINE_FEED = 8'h0A;
   localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;
   localparam string LETTERS = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   localparam string WORD_CHARS = {LETTERS, "0123456789"};
   localparam string DIGITS = "0123456789";
   localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
   localparam string PUNCTUATION = "{}():;=&|~^+-*/";
   localparam string BLANKS = " \011\012\013\014\015";

   // Predicts the token stream from the accepted source beats and checks
   // the tokens that leave the block against it.
   class token_scoreboard;
      scan_mode_type                mode;
      logic [elt_pkg::POS_BITS-1:0] position;
      logic [elt_pkg::POS_BITS-1:0] open_start;
      logic [15:0]                  open_length;
      int unsigned                  matched;
      keyword_type                  candidate;
      elt_pkg::token_type           expected_tokens[$];
      elt_pkg::token_type           beat_tokens[$];
      int unsigned                  failures;

      function new();
         failures = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         mode = SCAN_IDLE;
         position = '0;
         open_start = '0;
         open_length = '0;
         matched = 0;
         candidate = WORD_NONE;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit is_word(logic [7:0] c);
         return is_alpha(c) || is_digit(c) || c == "_";
      endfunction

      function bit is_hex_digit(logic [7:0] c);
         return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
      endfunction

      function void push_token(logic [4:0] kind, logic [elt_pkg::POS_BITS-1:0] start,
                               logic [15:0] length);
         elt_pkg::token_type t;
         t.kind = kind;
         t.start = start[15:0];
         t.length = length;
         t.last = 1'b0;
         beat_tokens.push_back(t);
      endfunction

      function void open_token(scan_mode_type next_mode);
         mode = next_mode;
         open_start = position;
         open_length = 16'd1;
      endfunction

      // The length of an open token sticks at its maximum.
      function void lengthen();
         if (open_length != 16'hFFFF) begin
            open_length++;
         end
      endfunction

      function void track_keyword(logic [7:0] c);
         string word;
         if (candidate == WORD_NONE) begin
            return;
         end
         if (candidate == WORD_SET) begin
            word = "set";
         end else begin
            word = "return";
         end
         if (matched < word.len() && word[matched] == c) begin
            matched++;
         end else begin
            candidate = WORD_NONE;
         end
      endfunction

      function logic [4:0] punctuation_kind(logic [7:0] c);
         case (c)
            "{": return elt_pkg::K_LBRACE;
            "}": return elt_pkg::K_RBRACE;
            "(": return elt_pkg::K_LPAREN;
            ")": return elt_pkg::K_RPAREN;
            ":": return elt_pkg::K_COLON;
            ";": return elt_pkg::K_SEMI;
            "=": return elt_pkg::K_ASSIGN;
            "&": return elt_pkg::K_AND;
            "|": return elt_pkg::K_OR;
            "~": return elt_pkg::K_NOT;
            "^": return elt_pkg::K_XOR;
            "+": return elt_pkg::K_PLUS;
            "-": return elt_pkg::K_MINUS;
            "*": return elt_pkg::K_STAR;
            default: return elt_pkg::K_UNKNOWN;
         endcase
      endfunction

      // Emit whatever token is open and go back to idle.
      function void close_open();
         case (mode)
            SCAN_WORD: begin
               if (candidate == WORD_SET && matched == 3) begin
                  push_token(elt_pkg::K_SET, open_start, open_length);
               end else if (candidate == WORD_RETURN && matched == 6) begin
                  push_token(elt_pkg::K_RETURN, open_start, open_length);
               end else begin
                  push_token(elt_pkg::K_ID, open_start, open_length);
               end
            end
            SCAN_DECIMAL, SCAN_ZERO: push_token(elt_pkg::K_DEC, open_start, open_length);
            SCAN_HEX: push_token(elt_pkg::K_HEX, open_start, open_length);
            SCAN_SLASH: push_token(elt_pkg::K_DIV, open_start, open_length);
            SCAN_GREATER, SCAN_LESS: push_token(elt_pkg::K_UNKNOWN, open_start, open_length);
            default: ;
         endcase
         mode = SCAN_IDLE;
         candidate = WORD_NONE;
         matched = 0;
      endfunction

      // A byte seen at a token boundary.
      function void first_byte(logic [7:0] c);
         mode = SCAN_IDLE;
         if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
            return;
         end
         if (is_alpha(c) || c == "_") begin
            open_token(SCAN_WORD);
            if (c == "s") begin
               candidate = WORD_SET;
            end else if (c == "r") begin
               candidate = WORD_RETURN;
            end else begin
               candidate = WORD_NONE;
            end
            matched = (candidate != WORD_NONE) ? 1 : 0;
         end else if (c == "0") begin
            open_token(SCAN_ZERO);
         end else if (is_digit(c)) begin
            open_token(SCAN_DECIMAL);
         end else if (c == "/") begin
            open_token(SCAN_SLASH);
         end else if (c == ">") begin
            open_token(SCAN_GREATER);
         end else if (c == "<") begin
            open_token(SCAN_LESS);
         end else begin
            push_token(punctuation_kind(c), position, 16'd1);
         end
      endfunction

      function void restart(logic [7:0] c);
         close_open();
         first_byte(c);
      endfunction

      // Work out the tokens that one accepted source beat causes.
      function void note_source_beat(logic [7:0] c, logic eos);
         beat_tokens.delete();
         if (eos || c == 8'd0) begin
            close_open();
            push_token(elt_pkg::K_END, position, 16'd0);
            clear_scan();
         end else begin
            case (mode)
               SCAN_COMMENT: begin
                  if (c == LINE_FEED || c == CARRIAGE_RETURN) begin
                     mode = SCAN_IDLE;
                  end
               end
               SCAN_WORD: begin
                  if (is_word(c)) begin
                     lengthen();
                     track_keyword(c);
                  end else begin
                     restart(c);
                  end
               end
               SCAN_DECIMAL: begin
                  if (is_digit(c)) begin
                     lengthen();
                  end else begin
                     restart(c);
                  end
               end
               SCAN_ZERO: begin
                  if (c == "x" || c == "X") begin
                     mode = SCAN_HEX;
                     lengthen();
                  end else if (is_digit(c)) begin
                     mode = SCAN_DECIMAL;
                     lengthen();
                  end else begin
                     restart(c);
                  end
               end
               SCAN_HEX: begin
                  if (is_hex_digit(c)) begin
                     lengthen();
                  end else begin
                     restart(c);
                  end
               end
               SCAN_SLASH: begin
                  if (c == "/") begin
                     mode = SCAN_COMMENT;
                  end else begin
                     restart(c);
                  end
               end
               SCAN_GREATER, SCAN_LESS: begin
                  if (mode == SCAN_GREATER && c == ">") begin
                     push_token(elt_pkg::K_RSHIFT, open_start, 16'd2);
                     mode = SCAN_IDLE;
                  end else if (mode == SCAN_LESS && c == "<") begin
                     push_token(elt_pkg::K_LSHIFT, open_start, 16'd2);
                     mode = SCAN_IDLE;
                  end else begin
                     restart(c);
                  end
               end
               default: first_byte(c);
            endcase
            position++;
         end
         if (beat_tokens.size() != 0) begin
            beat_tokens[beat_tokens.size() - 1].last = 1'b1;
         end
         foreach (beat_tokens[i]) begin
            expected_tokens.push_back(beat_tokens[i]);
         end
      endfunction

      // Compare one token from the block with the oldest prediction.
      function void check_token(elt_pkg::token_type got);
         elt_pkg::token_type want;
         if (expected_tokens.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("unexpected token: kind %0d start %0d length %0d last %0d",
                        got.kind, got.start, got.length, got.last);
            end
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind !== want.kind || got.start !== want.start ||
             got.length !== want.length || got.last !== want.last) begin
            failures++;
            if (failures <= 10) begin
               $display("token mismatch: expected kind %0d start %0d length %0d last %0d",
                        want.kind, want.start, want.length, want.last);
               $display("                got      kind %0d start %0d length %0d last %0d",
                        got.kind, got.start, got.length, got.last);
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_source_byte = 8'd0;
   logic        req_end_of_source = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_length;
   logic        rsp_last_of_item;

   token_scoreboard board = new();
   bit          calm = 1'b0;
   int          hold_requests = 0;
   int          random_items = 0;
   logic [8:0]  plan[$];

   expression_language_tokenizer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_source_byte(req_source_byte),
      .req_end_of_source(req_end_of_source),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind),
      .rsp_token_start(rsp_token_start),
      .rsp_token_length(rsp_token_length),
      .rsp_last_of_item(rsp_last_of_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, sometimes a short one, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 60) begin
         return 0;
      end
      if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] pick_char(string chars);
      return chars[$urandom_range(0, chars.len() - 1)];
   endfunction

   // Queue one byte of the plan; every byte is one source beat.
   function automatic void add_byte(logic [7:0] c);
      plan.push_back({1'b0, c});
      random_items++;
   endfunction

   // Append one random fragment of source text, mostly well formed.
   function automatic void build_fragment();
      string word;
      int    n;
      logic [7:0] c;
      case ($urandom_range(0, 15))
         0, 1: begin
            if ($urandom_range(0, 1)) begin
               word = "set";
            end else begin
               word = "return";
            end
            // Whole keyword, a prefix of it, or a longer word.
            n = ($urandom_range(0, 1)) ? word.len() : $urandom_range(1, word.len());
            for (int i = 0; i < n; i++) begin
               add_byte(word[i]);
            end
            if ($urandom_range(0, 2) == 0) begin
               add_byte(pick_char(WORD_CHARS));
            end
         end
         2, 13: begin
            add_byte(pick_char(LETTERS));
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++) begin
               add_byte(pick_char(WORD_CHARS));
            end
         end
         3: begin
            add_byte(pick_char("123456789"));
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
               add_byte(pick_char(DIGITS));
            end
         end
         4: begin
            add_byte("0");
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++) begin
               add_byte(pick_char(DIGITS));
            end
         end
         5: begin
            add_byte("0");
            add_byte(pick_char("xX"));
            n = $urandom_range(0, 5);
            for (int i = 0; i < n; i++) begin
               add_byte(pick_char(HEX_DIGITS));
            end
         end
         6: begin
            c = pick_char("<>");
            add_byte(c);
            add_byte(c);
         end
         7: add_byte(pick_char("<>"));
         8, 14, 15: add_byte(pick_char(PUNCTUATION));
         9: begin
            add_byte("/");
            add_byte("/");
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
               do begin
                  c = 8'($urandom_range(1, 255));
               end while (c == LINE_FEED || c == CARRIAGE_RETURN);
               add_byte(c);
            end
            if ($urandom_range(0, 4) != 0) begin
               add_byte($urandom_range(0, 1) ? LINE_FEED : CARRIAGE_RETURN);
            end
         end
         10: begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
               add_byte(pick_char(BLANKS));
            end
         end
         11: begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++) begin
               add_byte(8'($urandom_range(1, 255)));
            end
         end
         default: begin
            // End of source, by the marker or by a zero byte.
            if ($urandom_range(0, 1)) begin
               plan.push_back({1'b1, 8'($urandom_range(0, 255))});
            end else begin
               plan.push_back({1'b0, 8'h00});
            end
            random_items++;
         end
      endcase
      if ($urandom_range(0, 1)) begin
         add_byte(pick_char(BLANKS));
      end
   endfunction

   // Offer one source beat and hold it until the block takes it.
   task automatic send_beat(input logic [7:0] c, input logic eos);
      int gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source_byte <= c;
      req_end_of_source <= eos;
      do @(posedge clock); while (req_stall);
      board.note_source_beat(c, eos);
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) begin
         send_beat(text[i], 1'b0);
      end
   endtask

   // Stop offering and wait until every predicted token has arrived.
   task automatic drain_tokens();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.expected_tokens.size() != 0);
   endtask

   // Receiver: random stall runs, plus a long hold-off on request.
   initial begin
      int held;
      int served;
      served = 0;
      forever begin
         if (hold_requests != served) begin
            served = hold_requests;
            rsp_stall <= 1'b1;
            for (held = 0; held < 400; held++) @(posedge clock);
         end else begin
            rsp_stall <= !calm && $urandom_range(0, 2) == 0;
            repeat (1 + pick_gap()) @(posedge clock);
         end
      end
   end

   // Every token beat taken from the block is checked.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_token({rsp_token_kind, rsp_token_start, rsp_token_length,
                            rsp_last_of_item});
      end
   end

   initial begin
      bit paused;
      paused = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Hex without digits, leading zero, shifts, lone angle brackets, a held
      // slash that becomes division and then a comment, and a high byte.
      send_text("0x;0X1f 007<<>><>/a//c\n");
      send_beat(8'hFF, 1'b0);
      // A zero byte ends the source.
      send_beat(8'h00, 1'b0);
      // The end marker flushes an open keyword, then closes a comment.
      send_text("set");
      send_beat(8'h00, 1'b1);
      send_text("//x");
      send_beat(8'hFF, 1'b1);

      // Random source text.
      while (random_items < 1050) begin
         calm = ($urandom_range(0, 9) == 0);
         if (hold_requests == 0 && random_items >= 300) begin
            hold_requests = 1;
         end
         if (!paused && random_items >= 650) begin
            paused = 1'b1;
            drain_tokens();
         end
         plan.delete();
         build_fragment();
         foreach (plan[i]) begin
            send_beat(plan[i][7:0], plan[i][8]);
         end
      end

      // A long identifier sent without gaps, then a few tokens and an end
      // marker that flushes a lone angle bracket.
      calm = 1'b1;
      send_beat("_", 1'b0);
      repeat (40) send_beat(pick_char(WORD_CHARS), 1'b0);
      calm = 1'b0;
      send_text(" 12+x;0x<");
      send_beat(8'h00, 1'b1);

      drain_tokens();
      repeat (20) @(posedge clock);
      if (board.failures == 0 && board.expected_tokens.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   // Guard against a hung run.
   initial begin
      #10_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule

### files.f
src/elt_pkg.sv
src/elt_scan.sv
src/elt_queue.sv
src/expression_language_tokenizer.sv
tb/sv/testbench.sv
